@@ src/vpg_pkg.sv @@
// ----------------------------------------------------------------------------
// vpg_pkg
// Shared types, constants and elaboration-time waveform tables for the
// vibration pattern generator.
// ----------------------------------------------------------------------------
package vpg_pkg;

	localparam int TIME_BITS = 17;
	localparam int REM_W     = 15;
	localparam int NUM_MOD   = 8;

	localparam int MOD_2000  = 0;
	localparam int MOD_4000  = 1;
	localparam int MOD_500   = 2;
	localparam int MOD_10200 = 3;
	localparam int MOD_2400  = 4;
	localparam int MOD_18000 = 5;
	localparam int MOD_5000  = 6;
	localparam int MOD_9000  = 7;

	localparam int RECIP_W = 24;

	typedef logic [NUM_MOD-1:0][REM_W-1:0] rem_vec_t;

	localparam logic [REM_W-1:0] MOD_DIV [NUM_MOD] = '{
		15'd2000, 15'd4000, 15'd500, 15'd10200,
		15'd2400, 15'd18000, 15'd5000, 15'd9000
	};

	localparam logic [RECIP_W-1:0] MOD_RECIP [NUM_MOD] = '{
		RECIP_W'((64'd1 << 32) / 2000),  RECIP_W'((64'd1 << 32) / 4000),
		RECIP_W'((64'd1 << 32) / 500),   RECIP_W'((64'd1 << 32) / 10200),
		RECIP_W'((64'd1 << 32) / 2400),  RECIP_W'((64'd1 << 32) / 18000),
		RECIP_W'((64'd1 << 32) / 5000),  RECIP_W'((64'd1 << 32) / 9000)
	};

	typedef enum logic [3:0] {
		PAT_MUSCLE       = 4'd0,
		PAT_REVERSE      = 4'd1,
		PAT_RAMP         = 4'd2,
		PAT_WAVE         = 4'd3,
		PAT_SLOW_WAVE    = 4'd4,
		PAT_SINE         = 4'd5,
		PAT_TRIANGLE     = 4'd6,
		PAT_DOUBLE       = 4'd7,
		PAT_ANTI_FATIGUE = 4'd8,
		PAT_PULSE_RAMP   = 4'd9
	} pat_t;

	// ramps: duty = (6120000 + 119 t) / 80000, reverse (20400000 - 119 t) / 80000
	localparam int RAMP_W = 25;
	localparam int RAMP_MS = 120000;
	localparam logic [RAMP_W-1:0] RAMP_UP_BASE  = 25'd6120000;
	localparam logic [RAMP_W-1:0] RAMP_DN_BASE  = 25'd20400000;
	localparam logic [RAMP_W-1:0] RAMP_SLOPE    = 25'd119;
	localparam logic [RAMP_W-1:0] RAMP_DIV      = 25'd80000;
	localparam logic [15:0]       RAMP_RECIP    = 16'((64'd1 << 32) / 80000);

	// triangle ramps
	localparam int TRI_W = 21;
	localparam int TRI_RECIP_W = 22;

	function automatic logic [REM_W-1:0] tri_half(input logic [3:0] sel);
		case (sel)
			PAT_RAMP:      return 15'd5100;
			PAT_SLOW_WAVE: return 15'd9000;
			default:       return 15'd2000;
		endcase
	endfunction

	function automatic logic [TRI_RECIP_W-1:0] tri_recip(input logic [3:0] sel);
		case (sel)
			PAT_RAMP:      return TRI_RECIP_W'((64'd1 << 32) / 5100);
			PAT_SLOW_WAVE: return TRI_RECIP_W'((64'd1 << 32) / 9000);
			default:       return TRI_RECIP_W'((64'd1 << 32) / 2000);
		endcase
	endfunction

	function automatic logic [7:0] tri_span(input logic [3:0] sel);
		case (sel)
			PAT_RAMP:      return 8'd255;
			PAT_SLOW_WAVE: return 8'd150;
			default:       return 8'd140;
		endcase
	endfunction

	function automatic logic [7:0] tri_lo(input logic [3:0] sel);
		case (sel)
			PAT_RAMP:      return 8'd0;
			PAT_SLOW_WAVE: return 8'd50;
			default:       return 8'd60;
		endcase
	endfunction

	function automatic logic [7:0] tri_hi(input logic [3:0] sel);
		case (sel)
			PAT_RAMP: return 8'd255;
			default:  return 8'd200;
		endcase
	endfunction

	localparam logic [7:0] PULSE_LEVELS [9] = '{
		8'd120, 8'd150, 8'd180, 8'd210, 8'd240, 8'd210, 8'd180, 8'd150, 8'd120
	};

	// Q60 sine tables, built at elaboration
	localparam logic [63:0] PI_Q60 = 64'h3243F6A8885A308D;

	function automatic logic [63:0] qmul(input logic [63:0] a, input logic [63:0] b);
		logic [63:0] a0, a1, b0, b1, p00, p01, p10, p11, mid, lo, hi;
		a0  = {32'd0, a[31:0]};
		a1  = a >> 32;
		b0  = {32'd0, b[31:0]};
		b1  = b >> 32;
		p00 = a0 * b0;
		p01 = a0 * b1;
		p10 = a1 * b0;
		p11 = a1 * b1;
		mid = (p00 >> 32) + {32'd0, p01[31:0]} + {32'd0, p10[31:0]};
		lo  = {mid[31:0], p00[31:0]};
		hi  = p11 + (p01 >> 32) + (p10 >> 32) + (mid >> 32);
		return (hi << 4) | (lo >> 60);
	endfunction

	// restoring long division, small divisors only
	function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
		logic [63:0] q, r;
		q = '0;
		r = '0;
		for (int b = 63; b >= 0; b--) begin
			r = {r[62:0], n[b]};
			if (r >= d) begin
				r    = r - d;
				q[b] = 1'b1;
			end
		end
		return q;
	endfunction

	function automatic logic [63:0] taylor_sin(input logic [63:0] x);
		logic [63:0] x2, term, sum;
		x2   = qmul(x, x);
		term = x;
		sum  = x;
		for (int i = 1; i <= 14; i++) begin
			term = udiv64(qmul(term, x2), 64'(2 * i) * 64'(2 * i + 1));
			if (i % 2 == 1)
				sum = sum - term;
			else
				sum = sum + term;
		end
		return sum;
	endfunction

	function automatic logic [63:0] angle_1000(input logic [63:0] n);
		return (PI_Q60 / 1000) * n + ((PI_Q60 % 1000) * n) / 1000;
	endfunction

	function automatic logic [63:0] angle_2000(input logic [63:0] n);
		return (PI_Q60 / 2000) * n + ((PI_Q60 % 2000) * n) / 2000;
	endfunction

	function automatic logic [63:0] angle_250(input logic [63:0] n);
		return (PI_Q60 / 250) * n + ((PI_Q60 % 250) * n) / 250;
	endfunction

	localparam int SINE_N = 501;
	localparam int DBL_N  = 1001;
	localparam int RIP_N  = 126;

	function automatic logic [SINE_N*7-1:0] build_sine_rom();
		logic [SINE_N*7-1:0] rom;
		logic [63:0] m, ip;
		rom = '0;
		for (int n = 0; n < SINE_N; n++) begin
			m  = taylor_sin(angle_1000(64'(n)));
			ip = (64'd75 * (m >> 8)) >> 52;
			rom[n*7 +: 7] = ip[6:0];
		end
		return rom;
	endfunction

	function automatic logic [DBL_N*8-1:0] build_dbl_rom(input logic neg);
		logic [DBL_N*8-1:0] rom;
		logic [63:0] m, v, tot;
		rom = '0;
		for (int n = 0; n < DBL_N; n++) begin
			m   = taylor_sin(angle_2000(64'(n)));
			v   = 64'd185 * (m >> 8);
			tot = neg ? ((64'd325 << 52) - v) : ((64'd325 << 52) + v);
			rom[n*8 +: 8] = tot[60:53];
		end
		return rom;
	endfunction

	function automatic logic [RIP_N*5-1:0] build_rip_rom();
		logic [RIP_N*5-1:0] rom;
		logic [63:0] m, r;
		rom = '0;
		for (int n = 0; n < RIP_N; n++) begin
			m = taylor_sin(angle_250(64'(n)));
			r = (64'd30 * (m >> 8)) >> 52;
			rom[n*5 +: 5] = r[4:0];
		end
		return rom;
	endfunction

	localparam logic [SINE_N*7-1:0] SINE_ROM    = build_sine_rom();
	localparam logic [DBL_N*8-1:0]  DBL_POS_ROM = build_dbl_rom(1'b0);
	localparam logic [DBL_N*8-1:0]  DBL_NEG_ROM = build_dbl_rom(1'b1);
	localparam logic [RIP_N*5-1:0]  RIP_ROM     = build_rip_rom();

endpackage

@@ src/vpg_time_mod.sv @@
// ----------------------------------------------------------------------------
// vpg_time_mod
// Two-stage remainder unit: elapsed time modulo each waveform period, by
// reciprocal multiply in stage 1 and one correcting subtract in stage 2.
// ----------------------------------------------------------------------------
module vpg_time_mod
	import vpg_pkg::*;
(
	input  logic                 clk,
	input  logic                 en,
	input  logic [TIME_BITS-1:0] t,
	output rem_vec_t             rem
);

	localparam int PW = TIME_BITS + RECIP_W;

	logic [TIME_BITS-1:0] t_s1;
	logic [TIME_BITS-1:0] q_s1 [NUM_MOD];
	logic [PW-1:0]        prod [NUM_MOD];
	logic [TIME_BITS-1:0] r_est [NUM_MOD];
	rem_vec_t             rem_s2;

	always_comb begin
		for (int i = 0; i < NUM_MOD; i++) begin
			prod[i]  = PW'(t) * PW'(MOD_RECIP[i]);
			r_est[i] = t_s1 - q_s1[i] * TIME_BITS'(MOD_DIV[i]);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			t_s1 <= t;
			for (int i = 0; i < NUM_MOD; i++) begin
				q_s1[i] <= TIME_BITS'(prod[i] >> 32);
				if (r_est[i] >= TIME_BITS'(MOD_DIV[i]))
					rem_s2[i] <= REM_W'(r_est[i] - TIME_BITS'(MOD_DIV[i]));
				else
					rem_s2[i] <= REM_W'(r_est[i]);
			end
		end
	end

	assign rem = rem_s2;

endmodule

@@ src/vibration_pattern_generator_top.sv @@
// ----------------------------------------------------------------------------
// vibration_pattern_generator_top
// Five register stages lie between input accept and duty valid.
// Throughput: one item per cycle; an output stall holds the whole pipeline.
// Reset clears the stage valid bits only; payload registers are not reset.
// Maps pattern number and elapsed milliseconds to a motor PWM duty.
// ----------------------------------------------------------------------------
module vibration_pattern_generator_top
	import vpg_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [3:0]           pattern_select,
	input  logic [TIME_BITS-1:0] elapsed_ms,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [7:0]           duty
);

	logic en;
	logic valid_s1, valid_s2, valid_s3, valid_s4, valid_s5;
	logic [3:0] sel_s1, sel_s2, sel_s3, sel_s4, sel_s5;
	logic [TIME_BITS-1:0] t_s1;
	rem_vec_t rem_s2;

	// stage 2: ramp numerator
	logic [RAMP_W-1:0] x_s2, x_s3;
	logic over_s2, over_s3, over_s4, over_s5;
	logic [RAMP_W-1:0] ramp_prod;

	// stage 3
	logic [RAMP_W+15:0] ramp_mul;
	logic [8:0]         ramp_q_s3, ramp_q_s4;
	logic [RAMP_W-1:0]  ramp_r;

	logic [REM_W-1:0] tri_c, tri_half_c, tri_off;
	logic             tri_rise_s3, tri_rise_s4;
	logic [TRI_W-1:0] tri_num_s3, tri_num_s4;
	logic [TRI_W+TRI_RECIP_W-1:0] tri_mul;
	logic [8:0]       tri_q_s4;
	logic [TRI_W-1:0] tri_rem;
	logic [8:0]       tri_qf;

	logic [REM_W-1:0] sk, sa, dk, da, rj, ra;
	logic             sine_neg_s3, sine_exact_s3;
	logic [7:0]       sine_exact_val_s3;
	logic [8:0]       sine_idx_s3;
	logic             dbl_neg_s3, dbl_exact_s3;
	logic [7:0]       dbl_exact_val_s3;
	logic [9:0]       dbl_idx_s3;
	logic             rip_neg_s3, rip_exact_s3;
	logic [4:0]       rip_exact_val_s3;
	logic [6:0]       rip_idx_s3;

	logic [7:0] simple_c, simple_s3, simple_s4;
	logic [REM_W-1:0] wc, ac, pc;

	// stage 4
	logic       sine_neg_s4, sine_exact_s4;
	logic [7:0] sine_exact_val_s4;
	logic [6:0] sine_ip_s4;
	logic [7:0] dbl_base_s4;
	logic       rip_neg_s4;
	logic [4:0] rip_mag_s4;

	// stage 5
	logic [9:0] dbl_sum;
	logic [7:0] duty_c, duty_s5;

	assign en        = !(valid_s5 && out_stall);
	assign in_stall  = valid_s5 && out_stall;
	assign out_valid = valid_s5;
	assign duty      = duty_s5;

	vpg_time_mod u_time_mod (
		.clk (clk),
		.en  (en),
		.t   (elapsed_ms),
		.rem (rem_s2)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
		end
	end

	// stage 1 / 2 combinational
	assign ramp_prod = RAMP_W'(t_s1) * RAMP_SLOPE;

	// stage 3 combinational
	always_comb begin
		ramp_mul = (RAMP_W+16)'(x_s2) * (RAMP_W+16)'(RAMP_RECIP);

		case (sel_s2)
			PAT_RAMP:      tri_c = rem_s2[MOD_10200];
			PAT_SLOW_WAVE: tri_c = rem_s2[MOD_18000];
			default:       tri_c = rem_s2[MOD_4000];
		endcase
		tri_half_c = tri_half(sel_s2);
		tri_off    = (tri_c < tri_half_c) ? tri_c : tri_c - tri_half_c;

		sk = rem_s2[MOD_2000];
		sa = (sk >= 15'd1000) ? sk - 15'd1000 : sk;
		dk = rem_s2[MOD_4000];
		da = (dk >= 15'd2000) ? dk - 15'd2000 : dk;
		rj = rem_s2[MOD_500];
		ra = (rj >= 15'd250) ? rj - 15'd250 : rj;

		wc = rem_s2[MOD_2400];
		ac = rem_s2[MOD_5000];
		pc = rem_s2[MOD_9000];
		simple_c = 8'd0;
		case (sel_s2)
			PAT_WAVE: begin
				if (wc < 15'd100 || (wc >= 15'd400 && wc < 15'd900) ||
				    (wc >= 15'd1200 && wc < 15'd2200))
					simple_c = 8'd255;
			end
			PAT_ANTI_FATIGUE: begin
				for (int m = 0; m < 9; m++)
					if (ac >= REM_W'(500 * m) && ac < REM_W'(500 * m + 200))
						simple_c = 8'd225;
			end
			PAT_PULSE_RAMP: begin
				for (int m = 0; m < 9; m++)
					if (pc >= REM_W'(1000 * m) && pc < REM_W'(1000 * m + 200))
						simple_c = PULSE_LEVELS[m];
			end
			default: simple_c = 8'd0;
		endcase
	end

	// stage 4 / 5 combinational
	always_comb begin
		tri_mul = (TRI_W+TRI_RECIP_W)'(tri_num_s3) * (TRI_W+TRI_RECIP_W)'(tri_recip(sel_s3));
		ramp_r  = x_s3 - RAMP_W'(ramp_q_s3) * RAMP_DIV;

		tri_rem = tri_num_s4 - TRI_W'(tri_q_s4) * TRI_W'(tri_half(sel_s4));
		tri_qf  = (tri_rem >= TRI_W'(tri_half(sel_s4))) ? tri_q_s4 + 9'd1 : tri_q_s4;

		dbl_sum = rip_neg_s4 ? {2'b00, dbl_base_s4} - {5'd0, rip_mag_s4}
		                     : {2'b00, dbl_base_s4} + {5'd0, rip_mag_s4};

		case (sel_s4)
			PAT_MUSCLE, PAT_REVERSE:
				duty_c = over_s4 ? 8'd0 : ramp_q_s4[7:0];
			PAT_RAMP, PAT_SLOW_WAVE, PAT_TRIANGLE:
				duty_c = tri_rise_s4 ? tri_lo(sel_s4) + tri_qf[7:0]
				                     : tri_hi(sel_s4) - tri_qf[7:0];
			PAT_WAVE, PAT_ANTI_FATIGUE, PAT_PULSE_RAMP:
				duty_c = simple_s4;
			PAT_SINE: begin
				if (sine_exact_s4)
					duty_c = sine_exact_val_s4;
				else if (sine_neg_s4)
					duty_c = 8'd124 - {1'b0, sine_ip_s4};
				else
					duty_c = 8'd125 + {1'b0, sine_ip_s4};
			end
			PAT_DOUBLE: begin
				if (dbl_sum[9])
					duty_c = 8'd0;
				else if (dbl_sum[8])
					duty_c = 8'd255;
				else
					duty_c = dbl_sum[7:0];
			end
			default: duty_c = 8'd0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// stage 1
			sel_s1 <= pattern_select;
			t_s1   <= elapsed_ms;

			// stage 2
			sel_s2  <= sel_s1;
			over_s2 <= t_s1 > TIME_BITS'(RAMP_MS);
			x_s2    <= (sel_s1 == PAT_REVERSE) ? RAMP_DN_BASE - ramp_prod
			                                   : RAMP_UP_BASE + ramp_prod;

			// stage 3
			sel_s3      <= sel_s2;
			over_s3     <= over_s2;
			x_s3        <= x_s2;
			ramp_q_s3   <= 9'(ramp_mul >> 32);
			tri_rise_s3 <= tri_c < tri_half_c;
			tri_num_s3  <= TRI_W'(tri_off) * TRI_W'(tri_span(sel_s2));

			sine_neg_s3       <= sk >= 15'd1000;
			sine_idx_s3       <= 9'((sa > 15'd500) ? 15'd1000 - sa : sa);
			sine_exact_s3     <= sk == 15'd0 || sk == 15'd500 || sk == 15'd1000 ||
			                     sk == 15'd1500;
			sine_exact_val_s3 <= (sk == 15'd500) ? 8'd200 :
			                     (sk == 15'd1500) ? 8'd50 : 8'd125;

			dbl_neg_s3       <= dk >= 15'd2000;
			dbl_idx_s3       <= 10'((da > 15'd1000) ? 15'd2000 - da : da);
			dbl_exact_s3     <= dk == 15'd0 || dk == 15'd1000 || dk == 15'd2000 ||
			                    dk == 15'd3000;
			dbl_exact_val_s3 <= (dk == 15'd1000) ? 8'd255 :
			                    (dk == 15'd3000) ? 8'd70 : 8'd162;

			rip_neg_s3       <= rj >= 15'd250;
			rip_idx_s3       <= 7'((ra > 15'd125) ? 15'd250 - ra : ra);
			rip_exact_s3     <= rj == 15'd0 || rj == 15'd125 || rj == 15'd250 ||
			                    rj == 15'd375;
			rip_exact_val_s3 <= (rj == 15'd125 || rj == 15'd375) ? 5'd30 : 5'd0;

			simple_s3 <= simple_c;

			// stage 4
			sel_s4      <= sel_s3;
			over_s4     <= over_s3;
			ramp_q_s4   <= (ramp_r >= RAMP_DIV) ? ramp_q_s3 + 9'd1 : ramp_q_s3;
			tri_rise_s4 <= tri_rise_s3;
			tri_num_s4  <= tri_num_s3;
			tri_q_s4    <= 9'(tri_mul >> 32);

			sine_neg_s4       <= sine_neg_s3;
			sine_exact_s4     <= sine_exact_s3;
			sine_exact_val_s4 <= sine_exact_val_s3;
			sine_ip_s4        <= SINE_ROM[sine_idx_s3*7 +: 7];

			if (dbl_exact_s3)
				dbl_base_s4 <= dbl_exact_val_s3;
			else if (dbl_neg_s3)
				dbl_base_s4 <= DBL_NEG_ROM[dbl_idx_s3*8 +: 8];
			else
				dbl_base_s4 <= DBL_POS_ROM[dbl_idx_s3*8 +: 8];

			rip_neg_s4 <= rip_neg_s3;
			rip_mag_s4 <= rip_exact_s3 ? rip_exact_val_s3 : RIP_ROM[rip_idx_s3*5 +: 5];

			simple_s4 <= simple_s3;

			// stage 5
			sel_s5  <= sel_s4;
			over_s5 <= over_s4;
			duty_s5 <= duty_c;
		end
	end

`ifndef SYNTHESIS
	a_unknown_zero: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s5 && sel_s5 >= 4'd10 |-> duty_s5 == 8'd0)
		else $error("unknown pattern gave nonzero duty");

	a_ramp_end_zero: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s5 && over_s5 && (sel_s5 == PAT_MUSCLE || sel_s5 == PAT_REVERSE)
		|-> duty_s5 == 8'd0)
		else $error("ramp past its end gave nonzero duty");

	a_anti_levels: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s5 && sel_s5 == PAT_ANTI_FATIGUE |-> duty_s5 == 8'd0 || duty_s5 == 8'd225)
		else $error("anti-fatigue duty off its two levels");

	a_accept_enters: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> valid_s1)
		else $error("accepted item missing from stage 1");

	a_hold_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s4 && in_stall |=> valid_s4 && valid_s5)
		else $error("item dropped during stall");
`endif

endmodule
